// File: hw/rtl/iso2022_escape_decoder_macros.svh
// assertion helpers shared by the decoder files
// each macro samples on i_clk and is off while i_rst_n is low
`ifndef ISO2022_ESCAPE_DECODER_MACROS_SVH
`define ISO2022_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication
`define ISOESC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISOESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/isoesc_pkg.sv
`default_nettype none

package isoesc_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_CTRL = 2'd1,
        KIND_PEND = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        CS_ASCII    = 4'd0,
        CS_KATAKANA = 4'd1,
        CS_ROMAN    = 4'd2,
        CS_X0212    = 4'd3,
        CS_GB2312   = 4'd4,
        CS_IR165    = 4'd5,
        CS_JIS1978  = 4'd6,
        CS_X0208    = 4'd7,
        CS_KSC5601  = 4'd8
    } t_cset;

    typedef struct packed {
        t_kind       kind;
        t_cset       char_set;
        logic [15:0] code_value;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [1:0] idx;
    } t_gsel;

    // control bytes
    localparam logic [7:0] C_ESC = 8'h1B;
    localparam logic [7:0] C_SI  = 8'h0F;
    localparam logic [7:0] C_SO  = 8'h0E;

    // escape finals without intermediate
    localparam logic [7:0] C_LS2   = 8'h6E;
    localparam logic [7:0] C_LS3   = 8'h6F;
    localparam logic [7:0] C_SS2   = 8'h4E;
    localparam logic [7:0] C_SS2_8 = 8'h8E;
    localparam logic [7:0] C_SS3   = 8'h4F;
    localparam logic [7:0] C_SS3_8 = 8'h8F;
    localparam logic [7:0] C_LS1R  = 8'h7E;
    localparam logic [7:0] C_LS2R  = 8'h7D;
    localparam logic [7:0] C_LS3R  = 8'h7C;

    localparam logic [7:0] C_MULTI = 8'h24;

    localparam logic [15:0] C_KANA_BASE = 16'hFF40;
    localparam logic [15:0] C_YEN       = 16'h00A5;
    localparam logic [15:0] C_OVERLINE  = 16'h203E;
    localparam logic [15:0] C_ROW_LEN   = 16'd94;

    // set for a designation final, multi selects the ESC $ table for @ and B; A gives GB2312 either way
    function automatic t_cset f_final_set(input logic [7:0] f, input logic multi);
        t_cset cs;
        cs = CS_ASCII;
        case (f)
            8'h40: cs = multi ? CS_JIS1978 : CS_ASCII;
            8'h41: cs = CS_GB2312;
            8'h42: cs = multi ? CS_X0208 : CS_ASCII;
            8'h43: cs = CS_KSC5601;
            8'h44: cs = CS_X0212;
            8'h45: cs = CS_IR165;
            8'h49: cs = CS_KATAKANA;
            8'h4A: cs = CS_ROMAN;
            default: cs = CS_ASCII;
        endcase
        return cs;
    endfunction

    function automatic t_gsel f_g_select(input logic [7:0] i);
        t_gsel g;
        g = '{valid: 1'b1, idx: 2'd0};
        case (i)
            8'h28: g.idx = 2'd0;
            8'h29, 8'h2D: g.idx = 2'd1;
            8'h2A, 8'h2E: g.idx = 2'd2;
            8'h2B, 8'h2F: g.idx = 2'd3;
            default: g.valid = 1'b0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/isoesc_core.sv
`default_nettype none

`include "iso2022_escape_decoder_macros.svh"

module isoesc_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [7:0]          i_byte,
    output isoesc_pkg::t_result      o_res
);
    import isoesc_pkg::*;

    logic        r_in_escape,  n_in_escape;
    logic [7:0]  r_first_int,  n_first_int;
    logic [7:0]  r_second_int, n_second_int;
    logic [7:0]  r_lead_byte,  n_lead_byte;
    logic [1:0]  r_single_shift, n_single_shift;
    logic [1:0]  r_left_inv,   n_left_inv;
    logic [1:0]  r_right_inv,  n_right_inv;
    t_cset       r_desig [4];
    t_cset       n_desig [4];

    logic [6:0]  w_c;
    logic [1:0]  w_sel;
    t_cset       w_cs;
    logic [6:0]  w_row;
    logic [15:0] w_idx;
    logic        w_tail_bad;
    logic        w_lead_bad;
    t_gsel       w_g1;
    t_gsel       w_g2;
    t_result     w_res;

    assign w_c = i_byte[6:0];

    always_comb begin
        if (r_single_shift != 2'd0) begin
            w_sel = r_single_shift;
        end else if ((r_lead_byte != 8'h00) ? r_lead_byte[7] : i_byte[7]) begin
            w_sel = r_right_inv;
        end else begin
            w_sel = r_left_inv;
        end
    end

    assign w_cs  = r_desig[w_sel];
    assign w_row = r_lead_byte[6:0] - 7'h21;
    assign w_idx = {9'd0, w_row} * C_ROW_LEN + {9'd0, w_c} - 16'h0021;
    assign w_tail_bad = (w_c < 7'h21) || (w_c > 7'h7E);
    assign w_lead_bad = (w_cs == CS_X0212) ? ((w_c < 7'h22) || (w_c > 7'h6D)) : w_tail_bad;
    assign w_g1 = f_g_select(r_first_int);
    assign w_g2 = f_g_select(r_second_int);

    always_comb begin
        n_in_escape    = r_in_escape;
        n_first_int    = r_first_int;
        n_second_int   = r_second_int;
        n_lead_byte    = r_lead_byte;
        n_single_shift = r_single_shift;
        n_left_inv     = r_left_inv;
        n_right_inv    = r_right_inv;
        n_desig        = r_desig;
        w_res          = '{kind: KIND_CTRL, char_set: CS_ASCII, code_value: 16'd0};

        if (i_byte == C_ESC) begin
            n_in_escape = 1'b1;
        end else if (!r_in_escape) begin
            if (i_byte == C_SI) begin
                n_left_inv = 2'd0;
            end else if (i_byte == C_SO) begin
                n_left_inv = 2'd1;
            end else begin
                case (w_cs)
                    CS_ASCII, CS_KATAKANA, CS_ROMAN: begin
                        n_single_shift = 2'd0;
                        n_lead_byte    = 8'h00;
                        w_res.char_set = w_cs;
                        w_res.kind     = KIND_CHAR;
                        w_res.code_value = {9'd0, w_c};
                        if (w_cs == CS_KATAKANA) begin
                            if (w_c > 7'h20 && w_c < 7'h60) begin
                                w_res.code_value = C_KANA_BASE + {9'd0, w_c};
                            end else begin
                                w_res.kind       = KIND_ERR;
                                w_res.code_value = 16'd0;
                            end
                        end else if (w_cs == CS_ROMAN) begin
                            if (w_c == 7'h5C) begin
                                w_res.code_value = C_YEN;
                            end else if (w_c == 7'h7E) begin
                                w_res.code_value = C_OVERLINE;
                            end
                        end
                    end
                    CS_X0212, CS_GB2312, CS_IR165, CS_JIS1978, CS_X0208,
                    CS_KSC5601: begin
                        w_res.char_set = w_cs;
                        if (r_lead_byte == 8'h00) begin
                            if (w_lead_bad) begin
                                n_single_shift = 2'd0;
                                w_res.kind     = KIND_ERR;
                            end else begin
                                n_lead_byte = i_byte;
                                w_res.kind  = KIND_PEND;
                            end
                        end else begin
                            n_lead_byte    = 8'h00;
                            n_single_shift = 2'd0;
                            if (w_tail_bad || w_cs == CS_JIS1978) begin
                                w_res.kind = KIND_ERR;
                            end else begin
                                w_res.kind       = KIND_CHAR;
                                w_res.code_value = w_idx;
                            end
                        end
                    end
                    default: begin
                        n_single_shift = 2'd0;
                        n_lead_byte    = 8'h00;
                        w_res.kind     = KIND_ERR;
                    end
                endcase
            end
        end else if (r_first_int == 8'h00) begin
            if (i_byte[7:4] != 4'h2) begin
                n_in_escape  = 1'b0;
                n_first_int  = 8'h00;
                n_second_int = 8'h00;
                case (i_byte)
                    C_LS2:            n_left_inv     = 2'd2;
                    C_LS3:            n_left_inv     = 2'd3;
                    C_SS2, C_SS2_8:   n_single_shift = 2'd2;
                    C_SS3, C_SS3_8:   n_single_shift = 2'd3;
                    C_LS1R:           n_right_inv    = 2'd1;
                    C_LS2R:           n_right_inv    = 2'd2;
                    C_LS3R:           n_right_inv    = 2'd3;
                    default: begin
                    end
                endcase
            end else begin
                n_first_int = i_byte;
            end
        end else if (r_first_int != C_MULTI) begin
            if (w_g1.valid) begin
                n_desig[w_g1.idx] = f_final_set(i_byte, 1'b0);
            end
            n_in_escape  = 1'b0;
            n_first_int  = 8'h00;
            n_second_int = 8'h00;
        end else if (r_second_int == 8'h00) begin
            // ESC $ @ / A / B go to G0 directly
            if (i_byte >= 8'h40 && i_byte <= 8'h42) begin
                n_desig[0]   = f_final_set(i_byte, 1'b1);
                n_in_escape  = 1'b0;
                n_first_int  = 8'h00;
                n_second_int = 8'h00;
            end else begin
                n_second_int = i_byte;
            end
        end else begin
            n_in_escape  = 1'b0;
            n_first_int  = 8'h00;
            n_second_int = 8'h00;
            if (!w_g2.valid) begin
                w_res.kind = KIND_ERR;
            end else begin
                n_desig[w_g2.idx] = f_final_set(i_byte, 1'b1);
            end
        end
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_escape    <= 1'b0;
            r_first_int    <= 8'h00;
            r_second_int   <= 8'h00;
            r_lead_byte    <= 8'h00;
            r_single_shift <= 2'd0;
            r_left_inv     <= 2'd0;
            r_right_inv    <= 2'd1;
            r_desig        <= '{CS_ASCII, CS_ASCII, CS_ASCII, CS_ASCII};
        end else if (i_fire) begin
            r_in_escape    <= n_in_escape;
            r_first_int    <= n_first_int;
            r_second_int   <= n_second_int;
            r_lead_byte    <= n_lead_byte;
            r_single_shift <= n_single_shift;
            r_left_inv     <= n_left_inv;
            r_right_inv    <= n_right_inv;
            r_desig        <= n_desig;
        end
    end

    `ISOESC_ASSERT_IMP(a_lead_range, r_lead_byte != 8'h00, (r_lead_byte[6:0] >= 7'h21) && (r_lead_byte[6:0] <= 7'h7E), "pending lead byte out of range")
    `ISOESC_ASSERT_IMP(a_ss_code, 1'b1, r_single_shift != 2'd1, "single shift holds G1")
    `ISOESC_ASSERT_IMP(a_esc_clean, !r_in_escape, (r_first_int == 8'h00) && (r_second_int == 8'h00), "intermediate left outside escape")

endmodule

`default_nettype wire

// File: hw/rtl/iso2022_escape_decoder.sv
// ISO 2022 byte stream decoder.
// Slave stream: one raw byte per transfer on s_axis tdata.
// Master stream: one result per input byte; tuser carries kind and char set,
// tdata carries the code value (Unicode point or row*94+cell index).
// Kinds: character, control or escape byte consumed, lead byte pending, error.
// A byte is taken into an input register, decoded against the shift and
// designation state once the output register is free, and stored there.
// Throughput is one byte per cycle while the receiver does not stall; the
// decode is a single pass of logic between the input register and the
// output register, and the state it updates is ready for the following
// byte at the same edge.
// Reset clears both stages, leaves escape parsing idle, invokes G0 on GL
// and G1 on GR, and designates ASCII to all four G sets.
// When the receiver stalls, the output register holds its result, the
// input register holds one more byte, and s_axis tready drops only when
// both are full.
`default_nettype none

`include "iso2022_escape_decoder_macros.svh"

module iso2022_escape_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] code_value
    output logic [5:0]       o_m_axis_tuser    // [1:0] kind, [5:2] char_set
);
    import isoesc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out_res;

    logic        w_out_free;
    logic        w_adv;
    logic        w_in_take;
    t_result     w_res;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    isoesc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_res.code_value;
    assign o_m_axis_tuser  = {r_out_res.char_set, r_out_res.kind};

    `ISOESC_ASSERT_NEXT(a_adv_fills, w_adv, r_out_valid, "decoded byte did not reach output")
    `ISOESC_ASSERT_IMP(a_hold_full, r_in_valid && !w_adv, r_out_valid && !i_m_axis_tready, "input stage stalled without cause")
    `ISOESC_ASSERT_IMP(a_ctrl_zero, r_out_valid && (r_out_res.kind == KIND_CTRL), (r_out_res.char_set == CS_ASCII) && (r_out_res.code_value == 16'd0), "control result carries data")

endmodule

`default_nettype wire
